### design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5,
    PH_HALT  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_UNMASKED = 2'd2,
    KIND_TOOLONG  = 2'd3
  } kind_t;

  localparam logic [6:0]  LEN_EXT16         = 7'd126;
  localparam logic [6:0]  LEN_EXT64         = 7'd127;
  localparam logic [2:0]  EXT16_LAST        = 3'd1;
  localparam logic [2:0]  EXT64_LAST        = 3'd7;
  localparam logic [2:0]  KEY_LAST          = 3'd3;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16777216;
  localparam int          QUEUE_DEPTH       = 4;
  localparam int          QUEUE_AW          = $clog2(QUEUE_DEPTH);

  // One classified item handed from the parser to the output side.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic [31:0] frame_length;
    logic        last;
  } entry_t;

endpackage

### design/wsd_front.sv
// Header parser: accepts stream bytes, tracks the frame layout and
// turns payload bytes, empty frames and errors into queue entries. Depends on wsd_pkg.
module wsd_front import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] max_payload,
  input  logic        queue_full,
  output logic        push,
  output entry_t      push_entry
);

  phase_t      phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        mask_flag, mask_flag_next;
  logic [63:0] length_acc, length_acc_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [31:0] payload_pos, payload_pos_next;
  logic [31:0] max_len;

  logic        accept;
  logic [63:0] acc_shift;
  logic [63:0] len_chk;
  logic        mflag_chk;
  logic        len_complete;
  logic        err_unmasked;
  logic        err_long;
  logic [31:0] len_sat;
  logic        key_done;
  logic        data_last;
  logic [7:0]  key_byte;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign acc_shift = {length_acc[55:0], data_byte};

  always_comb begin
    len_chk   = acc_shift;
    mflag_chk = mask_flag;
    if (phase == PH_HDR1) begin
      len_chk   = {57'd0, data_byte[6:0]};
      mflag_chk = data_byte[7];
    end
    len_complete = ((phase == PH_HDR1) && (data_byte[6:0] != LEN_EXT16)
                    && (data_byte[6:0] != LEN_EXT64))
                || ((phase == PH_EXT16) && (byte_count == EXT16_LAST))
                || ((phase == PH_EXT64) && (byte_count == EXT64_LAST));
    err_unmasked = len_complete && !mflag_chk;
    err_long     = len_complete && mflag_chk && (len_chk > {32'd0, max_len});
    len_sat      = (len_chk[63:32] != 32'd0) ? 32'hFFFF_FFFF : len_chk[31:0];
    key_done     = (phase == PH_MASK) && (byte_count == KEY_LAST);
    data_last    = ({1'b0, payload_pos} + 33'd1) >= {1'b0, length_acc[31:0]};
    case (payload_pos[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next        = phase;
    frame_opcode_next = frame_opcode;
    mask_flag_next    = mask_flag;
    length_acc_next   = length_acc;
    byte_count_next   = byte_count;
    mask_key_next     = mask_key;
    payload_pos_next  = payload_pos;
    if (accept) begin
      case (phase)
        PH_HDR0: begin
          frame_opcode_next = data_byte[3:0];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          mask_flag_next  = data_byte[7];
          byte_count_next = 3'd0;
          length_acc_next = 64'd0;
          if (data_byte[6:0] == LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (data_byte[6:0] == LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            length_acc_next = len_chk;
            phase_next      = (err_unmasked || err_long) ? PH_HALT : PH_MASK;
          end
        end
        PH_EXT16, PH_EXT64: begin
          length_acc_next = acc_shift;
          if (len_complete) begin
            phase_next      = (err_unmasked || err_long) ? PH_HALT : PH_MASK;
            byte_count_next = 3'd0;
          end else begin
            byte_count_next = byte_count + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], data_byte};
          if (!key_done) begin
            byte_count_next = byte_count + 3'd1;
          end else begin
            byte_count_next  = 3'd0;
            payload_pos_next = 32'd0;
            phase_next       = (length_acc == 64'd0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_last) begin
            phase_next       = PH_HDR0;
            payload_pos_next = 32'd0;
          end else begin
            payload_pos_next = payload_pos + 32'd1;
          end
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end
  end

  // queue entries
  always_comb begin
    push                    = 1'b0;
    push_entry.kind         = KIND_BYTE;
    push_entry.data         = 8'd0;
    push_entry.key          = 8'd0;
    push_entry.opcode       = frame_opcode;
    push_entry.frame_length = len_sat;
    push_entry.last         = 1'b0;
    if (accept) begin
      case (phase)
        PH_HDR1, PH_EXT16, PH_EXT64: begin
          if (err_unmasked) begin
            push            = 1'b1;
            push_entry.kind = KIND_UNMASKED;
          end else if (err_long) begin
            push            = 1'b1;
            push_entry.kind = KIND_TOOLONG;
          end
        end
        PH_MASK: begin
          if (key_done && (length_acc == 64'd0)) begin
            push                    = 1'b1;
            push_entry.kind         = KIND_EMPTY;
            push_entry.frame_length = 32'd0;
            push_entry.last         = 1'b1;
          end
        end
        PH_DATA: begin
          push                    = 1'b1;
          push_entry.data         = data_byte;
          push_entry.key          = key_byte;
          push_entry.frame_length = length_acc[31:0];
          push_entry.last         = data_last;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_opcode <= 4'd0;
      mask_flag    <= 1'b0;
      length_acc   <= 64'd0;
      byte_count   <= 3'd0;
      mask_key     <= 32'd0;
      payload_pos  <= 32'd0;
      max_len      <= MAX_PAYLOAD_RESET;
    end else begin
      phase        <= phase_next;
      frame_opcode <= frame_opcode_next;
      mask_flag    <= mask_flag_next;
      length_acc   <= length_acc_next;
      byte_count   <= byte_count_next;
      mask_key     <= mask_key_next;
      payload_pos  <= payload_pos_next;
      if (cfg_valid) begin
        max_len <= max_payload;
      end
    end
  end

endmodule

### design/wsd_queue.sv
// Short queue of classified entries between parser and output stage.
// Depends on wsd_pkg for the entry type and depth.
module wsd_queue import wsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   nonempty,
  input  logic   pop,
  output entry_t head
);

  entry_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/wsd_back.sv
// Output stage: unmasks payload bytes and holds the result register.
// Depends on wsd_pkg for the entry type.
module wsd_back import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  output logic        pop,
  input  entry_t      head,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  opcode,
  output logic [31:0] frame_length,
  output logic        last
);

  assign pop = nonempty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind         <= head.kind;
      payload_byte <= head.data ^ head.key;
      opcode       <= head.opcode;
      frame_length <= head.frame_length;
      last         <= head.last;
    end
  end

endmodule

### design/websocket_frame_deframer_top.sv
// WebSocket frame deframer, receive side. Top level joining parser,
// queue and output stage. Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
//
// Input channel (in_valid/in_ready, data_byte): one stream byte per item.
// Output channel (out_valid/out_ready): kind, payload_byte, opcode,
// frame_length, last. Payload bytes come out unmasked; a zero-length frame
// gives one empty-frame item; an unmasked or too-long frame gives one error
// item and the parser then drops all further bytes until reset.
// Config channel (cfg_valid/cfg_ready, max_payload) writes the length limit;
// it is always ready.
// Throughput: one byte per cycle while the queue is not full. A result is
// written to the queue at the edge that accepts its byte and moves to the
// output register when the output stage pops it from the queue.
// A stalled receiver fills the four-entry queue; in_ready drops only when
// it is full. Header bytes need no queue slot but still wait while full.
// Reset clears the parser, empties the queue, drops out_valid and sets the
// limit to 16 MiB.
module websocket_frame_deframer_top import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] max_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  opcode,
  output logic [31:0] frame_length,
  output logic        last
);

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   nonempty;
  logic   pop;
  entry_t head;

  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .max_payload(max_payload),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .nonempty  (nonempty),
    .pop       (pop),
    .head      (head)
  );

  wsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .nonempty    (nonempty),
    .pop         (pop),
    .head        (head),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .payload_byte(payload_byte),
    .opcode      (opcode),
    .frame_length(frame_length),
    .last        (last)
  );

endmodule
